// ===== rtl/pll_loop_filter_two_integrator_assert.svh =====
// Assertion macros shared by the loop filter RTL.
// Both macros expect a signal named clk in the scope where they are used; PLF_ASSERT also needs rst_n.
`ifndef PLL_LOOP_FILTER_TWO_INTEGRATOR_ASSERT_SVH
`define PLL_LOOP_FILTER_TWO_INTEGRATOR_ASSERT_SVH

// Checked property, switched off while reset is held.
`define PLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds through reset.
`define PLF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/plf2i_pkg.sv =====
package plf2i_pkg;

  // Fixed-point formats: sample Q1.15, gains Q16.16, internal values Q8.24.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PROD_W    = 2 * WORD_W;
  localparam int unsigned CFG_IDX_W = 2;
  // Sample times k1 lands in Q17.31; shifting by 7 gives Q8.24.
  localparam int unsigned P1_SHIFT  = 7;
  // Q8.24 times a Q16.16 gain, back to Q8.24.
  localparam int unsigned GAIN_FRAC = 16;

  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // Reset gain k1 is 1.0 in Q16.16.
  localparam logic [WORD_W-1:0] GAIN_PROP_RST = 32'h0001_0000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RATIO_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RATIO_SECOND = 2'd2;

  // Operand selection for the shared multiplier.
  localparam logic [1:0] MUL_SAMPLE_K1 = 2'd0;
  localparam logic [1:0] MUL_P1_K2     = 2'd1;
  localparam logic [1:0] MUL_P12_K3    = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] val;
    logic              sat;
  } clip_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic [1:0] mul_op;
    logic       cap_p1;
    logic       cap_p12;
    logic       upd_int2;
    logic       upd_int1;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

  // Clip a 64-bit value to the signed 32-bit range.
  function automatic clip_t clip_prod(input logic [PROD_W-1:0] x);
    clip_t r;
    r.sat = (x[PROD_W-1:WORD_W-1] != {(PROD_W-WORD_W+1){1'b0}}) &&
            (x[PROD_W-1:WORD_W-1] != {(PROD_W-WORD_W+1){1'b1}});
    if (!r.sat) begin
      r.val = x[WORD_W-1:0];
    end else if (x[PROD_W-1]) begin
      r.val = WORD_MIN;
    end else begin
      r.val = WORD_MAX;
    end
    return r;
  endfunction

  // Add two signed words and clip the sum to the signed 32-bit range.
  function automatic clip_t add_clip(input logic [WORD_W-1:0] a,
                                     input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    clip_t           r;
    s     = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    r.sat = s[WORD_W] != s[WORD_W-1];
    if (!r.sat) begin
      r.val = s[WORD_W-1:0];
    end else if (s[WORD_W]) begin
      r.val = WORD_MIN;
    end else begin
      r.val = WORD_MAX;
    end
    return r;
  endfunction

endpackage

// ===== rtl/plf2i_if.sv =====
// Sample channel: one error sample and its mode bit per word.
interface plf2i_in_if;
  import plf2i_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] error_sample;
  logic                       mode;

  modport source (output valid, error_sample, mode, input ready);
  modport sink (input valid, error_sample, mode, output ready);
endinterface

// Result channel: one filter output and its saturation flag per word.
interface plf2i_out_if;
  import plf2i_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] loop_out;
  logic                     saturated;

  modport source (output valid, loop_out, saturated, input ready);
  modport sink (input valid, loop_out, saturated, output ready);
endinterface

// ===== rtl/plf2i_ctrl.sv =====
module plf2i_ctrl
  import plf2i_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_mode,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M1   = 4'd1;
  localparam logic [3:0] ST_C1   = 4'd2;
  localparam logic [3:0] ST_M2   = 4'd3;
  localparam logic [3:0] ST_C2   = 4'd4;
  localparam logic [3:0] ST_M3   = 4'd5;
  localparam logic [3:0] ST_C3   = 4'd6;
  localparam logic [3:0] ST_I1   = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Next state and the command word for each step.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_op = MUL_SAMPLE_K1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = in_mode ? ST_OUT : ST_M1;
        end
      end
      ST_M1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SAMPLE_K1;
        state_nxt  = ST_C1;
      end
      ST_C1: begin
        cmd.cap_p1 = 1'b1;
        state_nxt  = ST_M2;
      end
      ST_M2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_P1_K2;
        state_nxt  = ST_C2;
      end
      ST_C2: begin
        cmd.cap_p12 = 1'b1;
        state_nxt   = ST_M3;
      end
      ST_M3: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_P12_K3;
        state_nxt  = ST_C3;
      end
      ST_C3: begin
        cmd.upd_int2 = 1'b1;
        state_nxt    = ST_I1;
      end
      ST_I1: begin
        cmd.upd_int1 = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        // Hold here until the output register can take the word.
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/plf2i_dp.sv =====
module plf2i_dp
  import plf2i_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  input  logic [SAMPLE_W-1:0]  in_sample,
  input  logic                 in_mode,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_W-1:0]    out_word,
  output logic                 out_sat
);

  `include "pll_loop_filter_two_integrator_assert.svh"

  // Gains.
  logic [WORD_W-1:0] k1_r, k2_r, k3_r;

  // Per-word working registers.
  logic [SAMPLE_W-1:0] sample_r;
  logic                mode_r;
  logic [PROD_W-1:0]   prod_r;
  logic [WORD_W-1:0]   p1_r, p1_nxt;
  logic [WORD_W-1:0]   p12_r, p12_nxt;
  logic                sat_r, sat_nxt;

  // Integrator state.
  logic [WORD_W-1:0] first_acc_r, first_acc_nxt;
  logic [WORD_W-1:0] first_prev_r, first_prev_nxt;
  logic [WORD_W-1:0] second_acc_r, second_acc_nxt;
  logic [WORD_W-1:0] second_prev_r, second_prev_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_sat_r, out_sat_nxt;

  logic [WORD_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] prod_shr7, prod_shr16;
  clip_t             c_p1, c_p12, c_p123, c_acc2, c_in1, c_acc1, c_out;

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;
  assign out_sat      = out_sat_r;

  // Shared multiplier operand selection.
  always_comb begin
    unique case (cmd.mul_op)
      MUL_P1_K2: begin
        mul_a = p1_r;
        mul_b = k2_r;
      end
      MUL_P12_K3: begin
        mul_a = p12_r;
        mul_b = k3_r;
      end
      default: begin
        mul_a = {{(WORD_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
        mul_b = k1_r;
      end
    endcase
  end

  // Floor scaling of the registered product, then the clipped values.
  assign prod_shr7  = $signed(prod_r) >>> P1_SHIFT;
  assign prod_shr16 = $signed(prod_r) >>> GAIN_FRAC;
  assign c_p1   = clip_prod(prod_shr7);
  assign c_p12  = clip_prod(prod_shr16);
  assign c_p123 = clip_prod(prod_shr16);
  assign c_acc2 = add_clip(second_acc_r, second_prev_r);
  assign c_in1  = add_clip(p12_r, second_acc_r);
  assign c_acc1 = add_clip(first_acc_r, first_prev_r);
  assign c_out  = add_clip(p1_r, first_acc_r);

  // Next values of the working and integrator registers.
  always_comb begin
    p1_nxt          = p1_r;
    p12_nxt         = p12_r;
    sat_nxt         = sat_r;
    first_acc_nxt   = first_acc_r;
    first_prev_nxt  = first_prev_r;
    second_acc_nxt  = second_acc_r;
    second_prev_nxt = second_prev_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_word_nxt    = out_word_r;
    out_sat_nxt     = out_sat_r;

    if (cmd.load_in) begin
      sat_nxt = 1'b0;
    end
    if (cmd.cap_p1) begin
      p1_nxt  = c_p1.val;
      sat_nxt = sat_r | c_p1.sat;
    end
    if (cmd.cap_p12) begin
      p12_nxt = c_p12.val;
      sat_nxt = sat_r | c_p12.sat;
    end
    // Integrator two: accumulate the old input, then store the new one.
    if (cmd.upd_int2) begin
      second_acc_nxt  = c_acc2.val;
      second_prev_nxt = c_p123.val;
      sat_nxt         = sat_r | c_p123.sat | c_acc2.sat;
    end
    // Integrator one, fed by the k1*k2 path plus integrator two.
    if (cmd.upd_int1) begin
      first_acc_nxt  = c_acc1.val;
      first_prev_nxt = c_in1.val;
      sat_nxt        = sat_r | c_in1.sat | c_acc1.sat;
    end
    // Result word; a clear word zeroes all integrator state.
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      if (mode_r) begin
        out_word_nxt    = '0;
        out_sat_nxt     = 1'b0;
        first_acc_nxt   = '0;
        first_prev_nxt  = '0;
        second_acc_nxt  = '0;
        second_prev_nxt = '0;
      end else begin
        out_word_nxt = c_out.val;
        out_sat_nxt  = sat_r | c_out.sat;
      end
    end
  end

  // Output valid flag, gains and integrators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r          <= GAIN_PROP_RST;
      k2_r          <= '0;
      k3_r          <= '0;
      first_acc_r   <= '0;
      first_prev_r  <= '0;
      second_acc_r  <= '0;
      second_prev_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_PROP:         k1_r <= cfg_wdata;
          REG_GAIN_RATIO_FIRST:  k2_r <= cfg_wdata;
          REG_GAIN_RATIO_SECOND: k3_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      first_acc_r   <= first_acc_nxt;
      first_prev_r  <= first_prev_nxt;
      second_acc_r  <= second_acc_nxt;
      second_prev_r <= second_prev_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers and the multiplier output register.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample_r <= in_sample;
      mode_r   <= in_mode;
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'($signed(mul_a) * $signed(mul_b));
    end
    p1_r       <= p1_nxt;
    p12_r      <= p12_nxt;
    sat_r      <= sat_nxt;
    out_word_r <= out_word_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  // A clear word leaves every integrator word at zero.
  `PLF_ASSERT(a_clear_empties_state, (cmd.out_load && mode_r) |=> (first_acc_r == '0 && first_prev_r == '0 && second_acc_r == '0 && second_prev_r == '0), "integrator state not cleared")
  // A clear word is delivered as zero with no saturation.
  `PLF_ASSERT(a_clear_word_zero, (cmd.out_load && mode_r) |=> (out_word_r == '0 && !out_sat_r), "clear word not zero")
  // A new result is only loaded when the output register is free.
  `PLF_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_r || out_ready), "output word overwritten")
  // A pending result stays put until it is taken.
  `PLF_ASSERT(a_hold_pending, (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_word_r)), "pending word lost")

endmodule

// ===== rtl/pll_loop_filter_two_integrator.sv =====
// A process word is multiplied by k1, k2 and k3 in turn, updates integrators two and one,
// and is then loaded into the output register; a clear word goes straight to that load.
// A new sample is taken only after the last word is loaded. The single shared 32x32
// multiplier is used three times per sample, each product followed by shift-and-clip.
// Reset (synchronous, rst_n low): k1 = 1.0, k2 = k3 = 0, integrators and output valid cleared.
module pll_loop_filter_two_integrator
  import plf2i_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0]     cfg_wdata,
  plf2i_in_if.sink              in_ch,
  plf2i_out_if.source           out_ch
);

  cmd_t              cmd;
  sts_t              sts;
  logic              in_ready;
  logic              out_valid;
  logic [WORD_W-1:0] out_word;
  logic              out_sat;

  plf2i_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  plf2i_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_sample (in_ch.error_sample),
    .in_mode   (in_ch.mode),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word),
    .out_sat   (out_sat)
  );

  // Channel hookup.
  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.loop_out  = out_word;
  assign out_ch.saturated = out_sat;

endmodule
